[design/rnras_pkg.sv]
// Shared constants, types and constant functions of the rotary angle scaler.
package rnras_pkg;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [16:0] HALF_Q16  = 17'h08000;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [31:0] EXP_ONE   = 32'h4000_0000;

    typedef enum logic [1:0] {
        CFG_RATIO = 2'd0,
        CFG_STEEP = 2'd1,
        CFG_PAIRS = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RATIO = 2'd1,
        ST_SAT       = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  ipart;
        logic [15:0] fpart;
        logic [30:0] mant;
    } t_log;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bm;
        v   = v_in;
        res = '0;
        bm  = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bm) begin
                v   = v - (res + bm);
                res = (res >> 1) + bm;
            end else begin
                res = res >> 1;
            end
            bm = bm >> 2;
        end
        return res;
    endfunction

    // Factor 2^(2^(k-16)) in Q2.30, from repeated square roots of 2.0.
    function automatic logic [31:0] f_exp_root(input int k);
        logic [63:0] root;
        root = 64'h8000_0000;
        for (int i = 15; i >= k; i--) begin
            root = f_isqrt(root << 30);
        end
        return root[31:0];
    endfunction

endpackage

[design/rope_ntk_ramp_angle_scaler.sv]
// Top level of the rotary angle scaler with tanh ramp and context ratio power scale.
//
//  port group        dir   handshake       payload
//  start / busy      in    i_start, o_busy i_angle, i_dim_index
//  result            out   o_valid strobe  o_scaled_angle, o_ramp_value, o_scale_factor,
//                                          o_status
//  configuration     in    i_cfg_we        i_cfg_index, i_cfg_wdata
//
// One word is taken every cycle; busy stays low. Each word runs through two divider
// chains of 17 cells and two exponential chains of 16 cells plus glue stages; results
// show in word order, one per cycle.
// The logarithm of the ratio comes from a 16 cell chain that follows the ratio register.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall; every result is shown for exactly one cycle.
module rope_ntk_ramp_angle_scaler #(
    parameter int MAX_PAIRS = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_angle,
    input  logic [9:0]         i_dim_index,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_wdata,
    output logic               o_valid,
    output logic signed [31:0] o_scaled_angle,
    output logic [16:0]        o_ramp_value,
    output logic [31:0]        o_scale_factor,
    output logic [1:0]         o_status
);
    import rnras_pkg::*;

    localparam int LW = $clog2(MAX_PAIRS);
    localparam int PW = ($clog2(MAX_PAIRS + 1) > 10) ? $clog2(MAX_PAIRS + 1) : 10;

    typedef struct packed {
        logic [31:0] angle;
        logic        xneg;
        logic [4:0]  sh;
        logic        ezero;
    } t_e1_sb;

    typedef struct packed {
        logic [31:0] angle;
        logic        xneg;
    } t_d2_sb;

    typedef struct packed {
        logic [31:0] angle;
        logic [16:0] ramp;
        logic [3:0]  n;
        logic        sat;
    } t_e2_sb;

    localparam int E1_W = $bits(t_e1_sb);
    localparam int D2_W = $bits(t_d2_sb);
    localparam int E2_W = $bits(t_e2_sb);

    // Configuration registers.
    logic [23:0] r_ratio;
    logic [15:0] r_steep;
    logic [9:0]  r_pairs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= 24'd524288;
            r_steep <= 16'd4096;
            r_pairs <= 10'd64;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RATIO: r_ratio <= i_cfg_wdata;
                CFG_STEEP: r_steep <= i_cfg_wdata[15:0];
                CFG_PAIRS: r_pairs <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    logic [PW-1:0] w_p1;
    logic [PW-1:0] w_pcl;
    logic [LW-1:0] w_last;
    logic [8:0]    w_half;
    logic [LW-1:0] w_s;
    logic          w_ratio_ok;
    logic          w_accept;

    assign w_p1       = (r_pairs == 10'd0) ? PW'(1) : PW'(r_pairs);
    assign w_pcl      = (w_p1 > PW'(MAX_PAIRS)) ? PW'(MAX_PAIRS) : w_p1;
    assign w_last     = LW'(w_pcl - PW'(1));
    assign w_half     = i_dim_index[9:1];
    assign w_s        = (PW'(w_half) > PW'(w_last)) ? w_last : LW'(w_half);
    assign w_ratio_ok = (r_ratio > 24'h010000);
    assign o_busy     = 1'b0;
    assign w_accept   = i_start && !o_busy;

    // Logarithm of the ratio, tracking the register.
    logic [4:0]  w_lead;
    logic [54:0] w_norm;
    t_log        r_lg0;
    t_log        w_lg [0:16];
    logic [18:0] w_logv;

    always_comb begin
        w_lead = '0;
        for (int i = 0; i < 24; i++) begin
            if (r_ratio[i]) begin
                w_lead = 5'(i);
            end
        end
    end

    assign w_norm = 55'(r_ratio) << (5'd30 - w_lead);

    always_ff @(posedge i_clk) begin
        r_lg0.ipart <= 3'(w_lead - 5'd16);
        r_lg0.fpart <= '0;
        r_lg0.mant  <= w_norm[30:0];
    end

    assign w_lg[0] = r_lg0;

    for (genvar g = 0; g < 16; g++) begin : g_log
        rnras_log_cell u_cell (
            .i_clk  (i_clk),
            .i_cell (w_lg[g]),
            .o_cell (w_lg[g+1])
        );
    end

    assign w_logv = {w_lg[16].ipart, w_lg[16].fpart};

    // Entry stage.
    logic          r_e_vld;
    logic [31:0]   r_e_angle;
    logic [LW-1:0] r_e_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_angle <= i_angle;
        r_e_s     <= w_s;
    end

    // Pair position divider.
    logic          w_d1_vld [0:17];
    logic [LW-1:0] w_d1_den [0:17];
    logic [LW-1:0] w_d1_rem [0:17];
    logic [16:0]   w_d1_num [0:17];
    logic [16:0]   w_d1_quo [0:17];
    logic [31:0]   w_d1_sb  [0:17];

    assign w_d1_vld[0] = r_e_vld;
    assign w_d1_den[0] = w_last;
    assign w_d1_rem[0] = r_e_s >> 1;
    assign w_d1_num[0] = {r_e_s[0], 16'd0};
    assign w_d1_quo[0] = '0;
    assign w_d1_sb[0]  = r_e_angle;

    for (genvar g = 0; g < 17; g++) begin : g_div1
        rnras_div_cell #(.DEN_W(LW), .QW(17), .SB_W(32)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_d1_vld[g]),
            .i_den   (w_d1_den[g]),
            .i_rem   (w_d1_rem[g]),
            .i_num   (w_d1_num[g]),
            .i_quo   (w_d1_quo[g]),
            .i_sb    (w_d1_sb[g]),
            .o_vld   (w_d1_vld[g+1]),
            .o_den   (w_d1_den[g+1]),
            .o_rem   (w_d1_rem[g+1]),
            .o_num   (w_d1_num[g+1]),
            .o_quo   (w_d1_quo[g+1]),
            .o_sb    (w_d1_sb[g+1])
        );
    end

    // Ramp argument.
    logic [16:0] w_frac;
    logic        w_xneg;
    logic [17:0] w_twof;
    logic [17:0] w_dmag;
    logic [32:0] w_xprod;
    logic        r_x_vld;
    logic [31:0] r_x_angle;
    logic        r_x_xneg;
    logic [24:0] r_x_xmag;

    assign w_frac  = (w_last == '0) ? '0 : w_d1_quo[17];
    assign w_xneg  = (w_frac < HALF_Q16);
    assign w_twof  = {w_frac, 1'b0};
    assign w_dmag  = w_xneg ? (18'(ONE_Q16) - w_twof) : (w_twof - 18'(ONE_Q16));
    assign w_xprod = 33'(w_dmag[16:0]) * 33'(r_steep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld <= 1'b0;
        end else begin
            r_x_vld <= w_d1_vld[17];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_angle <= w_d1_sb[17];
        r_x_xneg  <= w_xneg;
        r_x_xmag  <= w_xprod[32:8];
    end

    logic [41:0] w_tprod;
    logic [43:0] w_tsum;
    logic        r_t_vld;
    logic [31:0] r_t_angle;
    logic        r_t_xneg;
    logic [26:0] r_t_t;

    assign w_tprod = 42'(r_x_xmag) * 42'(LOG2E_Q16);
    assign w_tsum  = {1'b0, w_tprod, 1'b0} + 44'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else begin
            r_t_vld <= r_x_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_angle <= r_x_angle;
        r_t_xneg  <= r_x_xneg;
        r_t_t     <= w_tsum[42:16];
    end

    // Exponential of the negative ramp argument.
    logic [10:0] w_tn;
    logic [15:0] w_tf;
    t_e1_sb      w_e1_in;
    logic        w_e1_vld [0:16];
    logic [31:0] w_e1_acc [0:16];
    logic [15:0] w_e1_f   [0:16];
    logic [E1_W-1:0] w_e1_sb [0:16];

    assign w_tn          = r_t_t[26:16];
    assign w_tf          = r_t_t[15:0];
    assign w_e1_in.angle = r_t_angle;
    assign w_e1_in.xneg  = r_t_xneg;
    assign w_e1_in.sh    = (w_tf == 16'd0) ? w_tn[4:0] : (w_tn[4:0] + 5'd1);
    assign w_e1_in.ezero = (w_tn >= 11'd31);

    assign w_e1_vld[0] = r_t_vld;
    assign w_e1_acc[0] = EXP_ONE;
    assign w_e1_f[0]   = ~w_tf + 16'd1;
    assign w_e1_sb[0]  = w_e1_in;

    for (genvar g = 0; g < 16; g++) begin : g_exp1
        rnras_exp_cell #(.K(15 - g), .SB_W(E1_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_e1_vld[g]),
            .i_acc   (w_e1_acc[g]),
            .i_f     (w_e1_f[g]),
            .i_sb    (w_e1_sb[g]),
            .o_vld   (w_e1_vld[g+1]),
            .o_acc   (w_e1_acc[g+1]),
            .o_f     (w_e1_f[g+1]),
            .o_sb    (w_e1_sb[g+1])
        );
    end

    // Logistic denominator.
    t_e1_sb      w_e1_out;
    logic [31:0] w_e;
    logic        r_d_vld;
    logic [31:0] r_d_angle;
    logic        r_d_xneg;
    logic [31:0] r_d_den;

    assign w_e1_out = w_e1_sb[16];
    assign w_e      = w_e1_out.ezero ? '0 : (w_e1_acc[16] >> w_e1_out.sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= w_e1_vld[16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_angle <= w_e1_out.angle;
        r_d_xneg  <= w_e1_out.xneg;
        r_d_den   <= EXP_ONE + w_e;
    end

    // Logistic divider.
    t_d2_sb      w_d2_in;
    logic        w_d2_vld [0:17];
    logic [31:0] w_d2_den [0:17];
    logic [31:0] w_d2_rem [0:17];
    logic [16:0] w_d2_num [0:17];
    logic [16:0] w_d2_quo [0:17];
    logic [D2_W-1:0] w_d2_sb [0:17];

    assign w_d2_in.angle = r_d_angle;
    assign w_d2_in.xneg  = r_d_xneg;

    assign w_d2_vld[0] = r_d_vld;
    assign w_d2_den[0] = r_d_den;
    assign w_d2_rem[0] = 32'h2000_0000 + (r_d_den >> 18);
    assign w_d2_num[0] = r_d_den[17:1];
    assign w_d2_quo[0] = '0;
    assign w_d2_sb[0]  = w_d2_in;

    for (genvar g = 0; g < 17; g++) begin : g_div2
        rnras_div_cell #(.DEN_W(32), .QW(17), .SB_W(D2_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_d2_vld[g]),
            .i_den   (w_d2_den[g]),
            .i_rem   (w_d2_rem[g]),
            .i_num   (w_d2_num[g]),
            .i_quo   (w_d2_quo[g]),
            .i_sb    (w_d2_sb[g]),
            .o_vld   (w_d2_vld[g+1]),
            .o_den   (w_d2_den[g+1]),
            .o_rem   (w_d2_rem[g+1]),
            .o_num   (w_d2_num[g+1]),
            .o_quo   (w_d2_quo[g+1]),
            .o_sb    (w_d2_sb[g+1])
        );
    end

    // Ramp and ramp times ratio minus one.
    t_d2_sb      w_d2_out;
    logic [16:0] w_q;
    logic [16:0] w_ramp;
    logic [23:0] w_ratio_m1;
    logic [40:0] w_raprod;
    logic [40:0] w_rasum;
    logic        r_r_vld;
    logic [31:0] r_r_angle;
    logic [16:0] r_r_ramp;
    logic [24:0] r_r_ra;

    assign w_d2_out   = w_d2_sb[17];
    assign w_q        = (w_d2_quo[17] > ONE_Q16) ? ONE_Q16 : w_d2_quo[17];
    assign w_ramp     = w_d2_out.xneg ? (ONE_Q16 - w_q) : w_q;
    assign w_ratio_m1 = r_ratio - 24'h010000;
    assign w_raprod   = 41'(w_ramp) * 41'(w_ratio_m1);
    assign w_rasum    = w_raprod + 41'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
        end else begin
            r_r_vld <= w_d2_vld[17];
        end
    end

    always_ff @(posedge i_clk) begin
        r_r_angle <= w_d2_out.angle;
        r_r_ramp  <= w_ramp;
        r_r_ra    <= w_rasum[40:16];
    end

    // Exponent of the scale.
    logic [43:0] w_exprod;
    logic [43:0] w_exsum;
    logic        r_l_vld;
    logic [31:0] r_l_angle;
    logic [16:0] r_l_ramp;
    logic [3:0]  r_l_n;
    logic        r_l_sat;
    logic [15:0] r_l_fex;

    assign w_exprod = 44'(r_r_ra) * 44'(w_logv);
    assign w_exsum  = w_exprod + 44'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_vld <= 1'b0;
        end else begin
            r_l_vld <= r_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l_angle <= r_r_angle;
        r_l_ramp  <= r_r_ramp;
        r_l_n     <= w_exsum[35:32];
        r_l_sat   <= |w_exsum[43:36];
        r_l_fex   <= w_exsum[31:16];
    end

    // Exponential of the scale exponent.
    t_e2_sb      w_e2_in;
    logic        w_e2_vld [0:16];
    logic [31:0] w_e2_acc [0:16];
    logic [15:0] w_e2_f   [0:16];
    logic [E2_W-1:0] w_e2_sb [0:16];

    assign w_e2_in.angle = r_l_angle;
    assign w_e2_in.ramp  = r_l_ramp;
    assign w_e2_in.n     = r_l_n;
    assign w_e2_in.sat   = r_l_sat;

    assign w_e2_vld[0] = r_l_vld;
    assign w_e2_acc[0] = EXP_ONE;
    assign w_e2_f[0]   = r_l_fex;
    assign w_e2_sb[0]  = w_e2_in;

    for (genvar g = 0; g < 16; g++) begin : g_exp2
        rnras_exp_cell #(.K(15 - g), .SB_W(E2_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_e2_vld[g]),
            .i_acc   (w_e2_acc[g]),
            .i_f     (w_e2_f[g]),
            .i_sb    (w_e2_sb[g]),
            .o_vld   (w_e2_vld[g+1]),
            .o_acc   (w_e2_acc[g+1]),
            .o_f     (w_e2_f[g+1]),
            .o_sb    (w_e2_sb[g+1])
        );
    end

    // Scale factor.
    t_e2_sb      w_e2_out;
    logic [46:0] w_shl;
    logic [46:0] w_scr;
    logic [31:0] w_scale;
    t_status     w_st;
    logic        r_s_vld;
    logic [31:0] r_s_angle;
    logic [16:0] r_s_ramp;
    logic [31:0] r_s_scale;
    t_status     r_s_status;

    assign w_e2_out = w_e2_sb[16];
    assign w_shl    = 47'(w_e2_acc[16]) << w_e2_out.n;
    assign w_scr    = w_shl + 47'h2000;

    always_comb begin
        if (!w_ratio_ok) begin
            w_scale = 32'(ONE_Q16);
            w_st    = ST_BAD_RATIO;
        end else if (w_e2_out.sat || w_scr[46]) begin
            w_scale = '1;
            w_st    = ST_SAT;
        end else begin
            w_scale = w_scr[45:14];
            w_st    = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= w_e2_vld[16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_angle  <= w_e2_out.angle;
        r_s_ramp   <= w_e2_out.ramp;
        r_s_scale  <= w_scale;
        r_s_status <= w_st;
    end

    // Angle times scale.
    logic        w_neg;
    logic [31:0] w_amag;
    logic [63:0] w_pm;
    logic [63:0] w_psum;
    logic        r_p_vld;
    logic        r_p_neg;
    logic [47:0] r_p_sa;
    logic [16:0] r_p_ramp;
    logic [31:0] r_p_scale;
    t_status     r_p_status;

    assign w_neg  = r_s_angle[31];
    assign w_amag = w_neg ? (~r_s_angle + 32'd1) : r_s_angle;
    assign w_pm   = 64'(w_amag) * 64'(r_s_scale);
    assign w_psum = w_pm + 64'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_neg    <= w_neg;
        r_p_sa     <= w_psum[63:16];
        r_p_ramp   <= r_s_ramp;
        r_p_scale  <= r_s_scale;
        r_p_status <= r_s_status;
    end

    // Saturation and output word.
    logic [31:0] w_mag;
    t_status     w_ost;
    logic        r_o_vld;
    logic [31:0] r_o_angle;
    logic [16:0] r_o_ramp;
    logic [31:0] r_o_scale;
    t_status     r_o_status;

    always_comb begin
        w_mag = r_p_sa[31:0];
        w_ost = r_p_status;
        if (!r_p_neg && (r_p_sa > 48'h0000_7FFF_FFFF)) begin
            w_mag = 32'h7FFF_FFFF;
            if (r_p_status == ST_OK) begin
                w_ost = ST_SAT;
            end
        end else if (r_p_neg && (r_p_sa > 48'h0000_8000_0000)) begin
            w_mag = 32'h8000_0000;
            if (r_p_status == ST_OK) begin
                w_ost = ST_SAT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_angle  <= r_p_neg ? (~w_mag + 32'd1) : w_mag;
        r_o_ramp   <= r_p_ramp;
        r_o_scale  <= r_p_scale;
        r_o_status <= w_ost;
    end

    assign o_valid        = r_o_vld;
    assign o_scaled_angle = signed'(r_o_angle);
    assign o_ramp_value   = r_o_ramp;
    assign o_scale_factor = r_o_scale;
    assign o_status       = r_o_status;
endmodule

[design/rnras_div_cell.sv]
// One restoring division step: one quotient bit per cell.
module rnras_div_cell #(
    parameter int DEN_W = 9,
    parameter int QW    = 17,
    parameter int SB_W  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [DEN_W-1:0] i_den,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [QW-1:0]    i_num,
    input  logic [QW-1:0]    i_quo,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_vld,
    output logic [DEN_W-1:0] o_den,
    output logic [DEN_W-1:0] o_rem,
    output logic [QW-1:0]    o_num,
    output logic [QW-1:0]    o_quo,
    output logic [SB_W-1:0]  o_sb
);
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    logic             r_vld;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [QW-1:0]    r_num;
    logic [QW-1:0]    r_quo;
    logic [SB_W-1:0]  r_sb;

    assign w_trial = {i_rem, i_num[QW-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= i_den;
        r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        r_num <= {i_num[QW-2:0], 1'b0};
        r_quo <= {i_quo[QW-2:0], w_ge};
        r_sb  <= i_sb;
    end

    assign o_vld = r_vld;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_sb  = r_sb;
endmodule

[design/rnras_exp_cell.sv]
// One step of the base-two exponential: multiplies in the factor for one fraction bit.
module rnras_exp_cell #(
    parameter int K    = 15,
    parameter int SB_W = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [31:0]     i_acc,
    input  logic [15:0]     i_f,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_vld,
    output logic [31:0]     o_acc,
    output logic [15:0]     o_f,
    output logic [SB_W-1:0] o_sb
);
    import rnras_pkg::*;

    localparam logic [31:0] ROOT = f_exp_root(K);

    logic [63:0]     w_prod;
    logic [63:0]     w_rnd;
    logic            r_vld;
    logic [31:0]     r_acc;
    logic [15:0]     r_f;
    logic [SB_W-1:0] r_sb;

    assign w_prod = 64'(i_acc) * 64'(ROOT);
    assign w_rnd  = w_prod + 64'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= i_f[K] ? w_rnd[61:30] : i_acc;
        r_f   <= i_f;
        r_sb  <= i_sb;
    end

    assign o_vld = r_vld;
    assign o_acc = r_acc;
    assign o_f   = r_f;
    assign o_sb  = r_sb;
endmodule

[design/rnras_log_cell.sv]
// One squaring step of the base-two logarithm: one fraction bit per cell.
module rnras_log_cell (
    input  logic            i_clk,
    input  rnras_pkg::t_log i_cell,
    output rnras_pkg::t_log o_cell
);
    import rnras_pkg::*;

    logic [61:0] w_sq;
    logic [31:0] w_m2;
    logic        w_bit;
    t_log        r_cell;

    assign w_sq  = 62'(i_cell.mant) * 62'(i_cell.mant);
    assign w_m2  = w_sq[61:30];
    assign w_bit = w_m2[31];

    always_ff @(posedge i_clk) begin
        r_cell.ipart <= i_cell.ipart;
        r_cell.fpart <= {i_cell.fpart[14:0], w_bit};
        r_cell.mant  <= w_bit ? w_m2[31:1] : w_m2[30:0];
    end

    assign o_cell = r_cell;
endmodule
